FILE: design/piecewise_linear_interpolator_unit_macros.svh
// Assertion macros for the piecewise linear interpolator unit.
// Included by the top level; no other dependencies.
`ifndef PIECEWISE_LINEAR_INTERPOLATOR_UNIT_MACROS_SVH
`define PIECEWISE_LINEAR_INTERPOLATOR_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define PLIU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define PLIU_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/pliu_pkg.sv
// Package for the piecewise linear interpolator: sizes, item structs, codes, states.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package pliu_pkg;

    // table geometry and value format (signed Q16.16)
    localparam int MAX_POINTS   = 16;
    localparam int IDX_W        = $clog2(MAX_POINTS);
    localparam int VALUE_W      = 32;
    localparam int CNT_W        = 5;
    localparam int POINT_COUNT_RESET = 2;

    // arithmetic widths: |dy| needs one bit more than a value
    localparam int MAG_W        = VALUE_W + 1;
    localparam int PROD_W       = MAG_W + VALUE_W;
    localparam int DIV_STEPS    = MAG_W;
    localparam int STEP_W       = $clog2(DIV_STEPS + 1);
    localparam int SUM_W        = VALUE_W + 3;

    // front queue between input side and engine
    localparam int FRONT_DEPTH  = 2;
    localparam int FPTR_W       = $clog2(FRONT_DEPTH);
    localparam int FCNT_W       = $clog2(FRONT_DEPTH + 1);

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        REGION_INTERIOR = 2'd0,
        REGION_LOW      = 2'd1,
        REGION_HIGH     = 2'd2
    } t_region;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIRST,
        S_LAST,
        S_SEARCH,
        S_MUL,
        S_DIV,
        S_SUM,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic                      opcode;
        logic [IDX_W-1:0]          entry_index;
        logic signed [VALUE_W-1:0] x_value;
        logic signed [VALUE_W-1:0] y_value;
    } t_in_item;

    typedef struct packed {
        logic signed [VALUE_W-1:0] result_value;
        logic [1:0]                region;
    } t_out_item;

    // classified item handed from the front queue to the engine
    typedef struct packed {
        t_op                       op;
        logic [IDX_W-1:0]          index;
        logic signed [VALUE_W-1:0] x;
        logic signed [VALUE_W-1:0] y;
    } t_cmd;

endpackage

FILE: design/piecewise_linear_interpolator_unit.sv
// Top level of the piecewise linear interpolator: front queue, engine, result register.
// Depends on pliu_pkg, pliu_front, pliu_back and the assertion macro header.
//
//   port group            direction   handshake            moves
//   i_item                in          push / full          load or query item
//   o_result              out         empty / pop          interpolated result item
//   i_cfg_data            in          i_cfg_valid / ready  point_count
//
// A load item is written into the table as it is taken and gives no result. A query that
// clamps ends once the first or last entry is compared; otherwise it searches the interval
// entry by entry through the single table read port, then multiplies, divides in the
// one-bit-per-cycle divider and sums. The front queue holds two items and keeps accepting
// until full while the engine works or a result waits. Reset is synchronous; the table
// holds no reset value and an entry reads as undefined until loaded.
`timescale 1ns / 1ps
`include "piecewise_linear_interpolator_unit_macros.svh"

module piecewise_linear_interpolator_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       push,
    output logic                       full,
    input  pliu_pkg::t_in_item         i_item,
    output logic                       empty,
    input  logic                       pop,
    output pliu_pkg::t_out_item        o_result,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [pliu_pkg::CNT_W-1:0] i_cfg_data
);
    import pliu_pkg::*;

    logic      w_cmd_valid;
    logic      w_cmd_take;
    t_cmd      w_cmd;
    logic      w_res_valid;
    logic      w_res_ready;
    logic      w_res_wait;
    t_out_item w_res;
    logic      r_out_valid;
    t_out_item r_out;

    pliu_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_item      (i_item),
        .o_cmd_valid (w_cmd_valid),
        .i_cmd_take  (w_cmd_take),
        .o_cmd       (w_cmd)
    );

    pliu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_take  (w_cmd_take),
        .i_cmd       (w_cmd),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res       (w_res)
    );

    // configuration is always taken
    assign o_cfg_ready = 1'b1;

    // result register: free when empty or being popped
    assign w_res_ready = !r_out_valid || pop;
    assign w_res_wait  = w_res_valid && !w_res_ready;
    assign empty       = !r_out_valid;
    assign o_result    = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid && w_res_ready) begin
            r_out_valid <= 1'b1;
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_res_ready) begin
            r_out <= w_res;
        end
    end

    // checks
    `PLIU_ASSERT_IMP(a_take_valid, i_clk, i_rst_n, w_cmd_take, w_cmd_valid, "take from empty queue")
    `PLIU_ASSERT_IMP(a_full_pend, i_clk, i_rst_n, full, w_cmd_valid, "full queue shows no item")
    `PLIU_ASSERT_NXT(a_res_held, i_clk, i_rst_n, w_res_wait, w_res_valid && $stable(w_res), "result lost")

endmodule

FILE: design/pliu_front.sv
// Front of the interpolator: two-entry item queue that decodes each item into a command.
// Depends on pliu_pkg.
`timescale 1ns / 1ps

module pliu_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    output logic            o_full,
    input  pliu_pkg::t_in_item i_item,
    output logic            o_cmd_valid,
    input  logic            i_cmd_take,
    output pliu_pkg::t_cmd  o_cmd
);
    import pliu_pkg::*;

    t_in_item          r_slot [FRONT_DEPTH];
    logic [FPTR_W-1:0] r_wr_ptr;
    logic [FPTR_W-1:0] r_rd_ptr;
    logic [FCNT_W-1:0] r_count;
    logic              w_wr;
    logic              w_rd;
    t_in_item          w_head;

    assign o_full      = (r_count == FCNT_W'(FRONT_DEPTH));
    assign o_cmd_valid = (r_count != '0);
    assign w_wr        = i_push && !o_full;
    assign w_rd        = i_cmd_take && o_cmd_valid;
    assign w_head      = r_slot[r_rd_ptr];

    // queue control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= r_wr_ptr + FPTR_W'(1);
            end
            if (w_rd) begin
                r_rd_ptr <= r_rd_ptr + FPTR_W'(1);
            end
            unique case ({w_wr, w_rd})
                2'b10:   r_count <= r_count + FCNT_W'(1);
                2'b01:   r_count <= r_count - FCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    // item storage
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_slot[r_wr_ptr] <= i_item;
        end
    end

    // decode the oldest item
    always_comb begin
        o_cmd.op    = t_op'(w_head.opcode);
        o_cmd.index = w_head.entry_index;
        o_cmd.x     = w_head.x_value;
        o_cmd.y     = w_head.y_value;
    end

endmodule

FILE: design/pliu_back.sv
// Back of the interpolator: breakpoint table, interval search, multiply, bit-serial divide,
// saturating sum. Depends on pliu_pkg.
`timescale 1ns / 1ps

module pliu_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [pliu_pkg::CNT_W-1:0] i_cfg_data,
    input  logic                 i_cmd_valid,
    output logic                 o_cmd_take,
    input  pliu_pkg::t_cmd       i_cmd,
    output logic                 o_res_valid,
    input  logic                 i_res_ready,
    output pliu_pkg::t_out_item  o_res
);
    import pliu_pkg::*;

    t_state r_state;
    t_state n_state;

    // point count register
    logic [CNT_W-1:0] r_point_count;
    logic [IDX_W-1:0] w_last;

    // table: {x, y} per entry, one write and one registered read per cycle
    logic [2*VALUE_W-1:0] r_mem [MAX_POINTS];
    logic [2*VALUE_W-1:0] r_rd_data;
    logic [IDX_W-1:0]     w_rd_addr;
    logic                 w_mem_we;
    logic signed [VALUE_W-1:0] w_ent_x;
    logic signed [VALUE_W-1:0] w_ent_y;

    // query working registers
    logic signed [VALUE_W-1:0] r_xv;
    logic signed [VALUE_W-1:0] r_px;
    logic signed [VALUE_W-1:0] r_py;
    logic [IDX_W-1:0]          r_last;
    logic [IDX_W-1:0]          r_j;
    logic [MAG_W-1:0]          r_mag;
    logic [VALUE_W-1:0]        r_num;
    logic [VALUE_W-1:0]        r_den;
    logic                      r_neg;
    logic [VALUE_W-1:0]        r_rem;
    logic [DIV_STEPS-1:0]      r_quo;
    logic [STEP_W-1:0]         r_step;
    logic signed [VALUE_W-1:0] r_res;
    t_region                   r_region;

    logic                      w_le_first;
    logic                      w_ge_last;
    logic                      w_advance;
    logic signed [MAG_W-1:0]   w_dy;
    logic [MAG_W-1:0]          w_mag;
    logic [PROD_W-1:0]         w_prod;
    logic [VALUE_W:0]          w_trial;
    logic [VALUE_W:0]          w_diff;
    logic                      w_ge;
    logic signed [SUM_W-1:0]   w_quo_ext;
    logic signed [SUM_W-1:0]   w_q;
    logic signed [SUM_W-1:0]   w_py_ext;
    logic signed [SUM_W-1:0]   w_sum;
    logic [SUM_W-VALUE_W:0]    w_sum_hi;
    logic signed [VALUE_W-1:0] w_sat;

    // configuration write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count <= CNT_W'(POINT_COUNT_RESET);
        end else if (i_cfg_valid) begin
            r_point_count <= i_cfg_data;
        end
    end

    // index of the last entry in use, count held to 2..MAX_POINTS
    always_comb begin
        priority if (r_point_count < CNT_W'(2)) begin
            w_last = IDX_W'(1);
        end else if (r_point_count > CNT_W'(MAX_POINTS)) begin
            w_last = IDX_W'(MAX_POINTS - 1);
        end else begin
            w_last = IDX_W'(r_point_count - CNT_W'(1));
        end
    end

    // table memory
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[i_cmd.index] <= {i_cmd.x, i_cmd.y};
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    assign w_ent_x = r_rd_data[2*VALUE_W-1:VALUE_W];
    assign w_ent_y = r_rd_data[VALUE_W-1:0];

    // compares for clamping and search
    assign w_le_first = (r_xv <= w_ent_x);
    assign w_ge_last  = (r_xv >= w_ent_x);
    assign w_advance  = (r_j != r_last) && (w_ent_x < r_xv);

    // slope terms; x differences are positive and fit VALUE_W bits
    assign w_dy  = {w_ent_y[VALUE_W-1], w_ent_y} - {r_py[VALUE_W-1], r_py};
    assign w_mag = w_dy[MAG_W-1] ? (~w_dy + MAG_W'(1)) : w_dy;

    // product |dy| * (x - x0)
    assign w_prod = PROD_W'(r_mag) * PROD_W'(r_num);

    // one restoring division step
    assign w_trial = {r_rem, r_quo[DIV_STEPS-1]};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign w_ge    = (w_trial >= {1'b0, r_den});

    // signed quotient plus y0, saturated to VALUE_W bits
    assign w_quo_ext = {{(SUM_W-DIV_STEPS){1'b0}}, r_quo};
    assign w_q       = r_neg ? -w_quo_ext : w_quo_ext;
    assign w_py_ext  = {{(SUM_W-VALUE_W){r_py[VALUE_W-1]}}, r_py};
    assign w_sum     = w_py_ext + w_q;
    assign w_sum_hi  = w_sum[SUM_W-1:VALUE_W-1];

    always_comb begin
        if ((&w_sum_hi) || !(|w_sum_hi)) begin
            w_sat = w_sum[VALUE_W-1:0];
        end else if (w_sum[SUM_W-1]) begin
            w_sat = {1'b1, {(VALUE_W-1){1'b0}}};
        end else begin
            w_sat = {1'b0, {(VALUE_W-1){1'b1}}};
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && (i_cmd.op == OP_QUERY)) begin
                    n_state = S_FIRST;
                end
            end
            S_FIRST:  n_state = w_le_first ? S_RESULT : S_LAST;
            S_LAST:   n_state = w_ge_last ? S_RESULT : S_SEARCH;
            S_SEARCH: begin
                if (!w_advance) begin
                    n_state = S_MUL;
                end
            end
            S_MUL:    n_state = S_DIV;
            S_DIV: begin
                if (r_step == STEP_W'(1)) begin
                    n_state = S_SUM;
                end
            end
            S_SUM:    n_state = S_RESULT;
            S_RESULT: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_cmd_take  = 1'b0;
        w_mem_we    = 1'b0;
        w_rd_addr   = '0;
        o_res_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd_take = i_cmd_valid;
                w_mem_we   = i_cmd_valid && (i_cmd.op == OP_LOAD);
            end
            S_FIRST:  w_rd_addr = r_last;
            S_LAST:   w_rd_addr = IDX_W'(1);
            S_SEARCH: w_rd_addr = r_j + IDX_W'(1);
            S_RESULT: o_res_valid = 1'b1;
            default: begin
            end
        endcase
    end

    // query datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    r_xv   <= i_cmd.x;
                    r_last <= w_last;
                end
            end
            S_FIRST: begin
                if (w_le_first) begin
                    r_res    <= w_ent_y;
                    r_region <= REGION_LOW;
                end else begin
                    r_px <= w_ent_x;
                    r_py <= w_ent_y;
                end
            end
            S_LAST: begin
                if (w_ge_last) begin
                    r_res    <= w_ent_y;
                    r_region <= REGION_HIGH;
                end else begin
                    r_j <= IDX_W'(1);
                end
            end
            S_SEARCH: begin
                if (w_advance) begin
                    r_px <= w_ent_x;
                    r_py <= w_ent_y;
                    r_j  <= r_j + IDX_W'(1);
                end else begin
                    r_mag <= w_mag;
                    r_neg <= w_dy[MAG_W-1];
                    r_num <= r_xv - r_px;
                    r_den <= w_ent_x - r_px;
                end
            end
            S_MUL: begin
                r_rem  <= w_prod[PROD_W-1:DIV_STEPS];
                r_quo  <= w_prod[DIV_STEPS-1:0];
                r_step <= STEP_W'(DIV_STEPS);
            end
            S_DIV: begin
                r_rem  <= w_ge ? w_diff[VALUE_W-1:0] : w_trial[VALUE_W-1:0];
                r_quo  <= {r_quo[DIV_STEPS-2:0], w_ge};
                r_step <= r_step - STEP_W'(1);
            end
            S_SUM: begin
                r_res    <= w_sat;
                r_region <= REGION_INTERIOR;
            end
            default: begin
            end
        endcase
    end

    assign o_res.result_value = r_res;
    assign o_res.region       = r_region;

endmodule
